// ===== src/hses_pkg.sv =====
package hses_pkg;

	localparam int LONG_DEPTH_DEF   = 100;
	localparam int MEDIUM_DEPTH_DEF = 10;
	localparam int SHORT_DEPTH_DEF  = 5;

	localparam int SPEED_W = 24;
	localparam int TIME_W  = 32;
	localparam int SUM_W   = 32;
	localparam int DIV_W   = 32;

	typedef enum logic [1:0] {
		WIN_LONG   = 2'd0,
		WIN_MEDIUM = 2'd1,
		WIN_SHORT  = 2'd2
	} win_t;

	typedef enum logic [1:0] {
		REG_FAST  = 2'd0,
		REG_SLOW  = 2'd1,
		REG_STALL = 2'd2,
		REG_KSPD  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDOLD,
		ST_DIV1,
		ST_WRITE,
		ST_DIV2,
		ST_DONE,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   num;
		logic [DIV_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIV_W-1:0]   quo;
	} div_rsp_t;

	function automatic logic is_sector_code(input logic signed [15:0] a);
		return a == 16'sd27308 || a == 16'sd16384 || a == 16'sd5461 ||
			a == -16'sd5461 || a == -16'sd16383 || a == -16'sd27305;
	endfunction

endpackage

// ===== src/hses_divider.sv =====
module hses_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  hses_pkg::div_req_t req,
	output hses_pkg::div_rsp_t rsp
);
	import hses_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   shifted;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== src/hall_edge_speed_estimator.sv =====
// hall edge speed estimator
// input channel: in_valid/in_ready with req_type, hall_angle, time_us and
// commanded_speed. each accepted item gives exactly one result item on
// out_valid/out_ready carrying speed_average.
// a clear item (req_type 1) sweeps the three windows, one entry per
// cycle. a new edge passes through the shared 32-step restoring divider
// twice (speed, then average), or once (average only) when dt is zero,
// plus a window memory read and write.
// one item is worked at a time; in_ready is low while an item is at work
// or while its result waits in the output register. configuration:
// cfg_we/cfg_addr/cfg_wdata, taken at once; the user must write it only
// while idle, the block does not enforce this. reset: asynchronous,
// active low on arst_n. registers that have a reset take their reset
// values; after reset a sweep zeroes the window memories, during which
// no item is accepted. a stalled receiver holds the result in the output
// register and the block takes no new item until it is delivered.
module hall_edge_speed_estimator #(
	parameter int LONG_DEPTH   = hses_pkg::LONG_DEPTH_DEF,
	parameter int MEDIUM_DEPTH = hses_pkg::MEDIUM_DEPTH_DEF,
	parameter int SHORT_DEPTH  = hses_pkg::SHORT_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic signed [15:0]  hall_angle,
	input  logic [31:0]         time_us,
	input  logic signed [31:0]  commanded_speed,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [23:0]         speed_average,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [31:0]         cfg_wdata
);
	import hses_pkg::*;

	localparam int LI_W = $clog2(LONG_DEPTH);
	localparam int MI_W = $clog2(MEDIUM_DEPTH);
	localparam int SI_W = $clog2(SHORT_DEPTH);
	localparam int CL_W = $clog2(LONG_DEPTH + 1);

	logic signed [31:0] fast_q, slow_q;
	logic [31:0]        stall_q;
	logic [23:0]        kspd_q;

	logic [SPEED_W-1:0] long_mem   [LONG_DEPTH];
	logic [SPEED_W-1:0] medium_mem [MEDIUM_DEPTH];
	logic [SPEED_W-1:0] short_mem  [SHORT_DEPTH];

	logic [LI_W-1:0]    long_idx_q;
	logic [MI_W-1:0]    med_idx_q;
	logic [SI_W-1:0]    short_idx_q;
	logic [2:0]         full_q;
	logic [SUM_W-1:0]   sum_q [3];
	logic [SPEED_W-1:0] held_q;
	logic [15:0]        last_angle_q;
	logic [TIME_W-1:0]  last_time_q;

	state_t             state_q, state_d;
	win_t               win_q;
	logic [TIME_W-1:0]  now_q;
	logic [15:0]        angle_q;
	logic               req_q;
	logic signed [31:0] cmd_q;
	logic [SPEED_W-1:0] old_q;
	logic [SPEED_W-1:0] speed_q;
	logic [CL_W-1:0]    clr_q;
	logic               out_valid_q;
	logic [SPEED_W-1:0] out_q;

	div_req_t dreq;
	div_rsp_t drsp;

	hses_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	logic [TIME_W-1:0] dt;
	win_t              win_sel;
	logic              is_code, new_edge, cur_full;
	logic [7:0]        cur_idx;
	logic [8:0]        cur_depth;
	logic [SUM_W-1:0]  new_sum;

	assign dt       = now_q - last_time_q;
	assign win_sel  = (cmd_q >= fast_q) ? WIN_LONG :
		((cmd_q >= slow_q) ? WIN_MEDIUM : WIN_SHORT);
	assign is_code  = is_sector_code(angle_q);
	assign new_edge = angle_q != last_angle_q;

	always_comb begin
		cur_full  = full_q[win_q];
		cur_idx   = '0;
		cur_depth = '0;
		unique case (win_q)
			WIN_LONG: begin
				cur_idx   = 8'(long_idx_q);
				cur_depth = 9'(LONG_DEPTH);
			end
			WIN_MEDIUM: begin
				cur_idx   = 8'(med_idx_q);
				cur_depth = 9'(MEDIUM_DEPTH);
			end
			default: begin
				cur_idx   = 8'(short_idx_q);
				cur_depth = 9'(SHORT_DEPTH);
			end
		endcase
		new_sum = sum_q[win_q] - (cur_full ? SUM_W'(old_q) : '0) + SUM_W'(speed_q);
	end

	always_comb begin
		state_d    = state_q;
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		unique case (state_q)
			ST_CLEAR: if (clr_q == CL_W'(LONG_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (in_valid && in_ready) begin
				state_d = ST_RDOLD;
			end
			ST_RDOLD: begin
				if (req_q) state_d = ST_CLEAR;
				else if (is_code && new_edge && dt != '0) begin
					state_d    = ST_DIV1;
					dreq.start = 1'b1;
					dreq.num   = DIV_W'(kspd_q);
					dreq.den   = dt;
				end else if (is_code && new_edge) state_d = ST_WRITE;
				else state_d = ST_DONE;
			end
			ST_DIV1: if (drsp.done) state_d = ST_WRITE;
			ST_WRITE: begin
				state_d    = ST_DIV2;
				dreq.start = 1'b1;
				dreq.num   = new_sum;
				dreq.den   = cur_full ? DIV_W'(cur_depth) : DIV_W'(cur_idx) + 1'b1;
			end
			ST_DIV2: if (drsp.done) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready      = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid     = out_valid_q;
	assign speed_average = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q       <= 32'sd800;
			slow_q       <= 32'sd300;
			stall_q      <= 32'd1000000;
			kspd_q       <= 24'd5000000;
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
			long_idx_q   <= '0;
			med_idx_q    <= '0;
			short_idx_q  <= '0;
			full_q       <= '0;
			sum_q[0]     <= '0;
			sum_q[1]     <= '0;
			sum_q[2]     <= '0;
			held_q       <= '0;
			last_angle_q <= '0;
			last_time_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_addr))
					REG_FAST:  fast_q  <= cfg_wdata;
					REG_SLOW:  slow_q  <= cfg_wdata;
					REG_STALL: stall_q <= cfg_wdata;
					default:   kspd_q  <= cfg_wdata[23:0];
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_RDOLD: begin
					clr_q <= '0;
					if (req_q) begin
						long_idx_q   <= '0;
						med_idx_q    <= '0;
						short_idx_q  <= '0;
						full_q       <= '0;
						sum_q[0]     <= '0;
						sum_q[1]     <= '0;
						sum_q[2]     <= '0;
						held_q       <= '0;
						last_angle_q <= '0;
						out_valid_q  <= 1'b1;
					end else if (is_code) begin
						if (win_sel != WIN_LONG) begin
							long_idx_q <= '0;
							full_q[0]  <= 1'b0;
							sum_q[0]   <= '0;
						end
						if (win_sel != WIN_MEDIUM) begin
							med_idx_q <= '0;
							full_q[1] <= 1'b0;
							sum_q[1]  <= '0;
						end
						if (win_sel != WIN_SHORT) begin
							short_idx_q <= '0;
							full_q[2]   <= 1'b0;
							sum_q[2]    <= '0;
						end
						if (win_sel == WIN_SHORT && dt > stall_q) held_q <= '0;
					end
				end
				ST_WRITE: begin
					sum_q[win_q] <= new_sum;
					last_angle_q <= angle_q;
					last_time_q  <= now_q;
					if (32'(cur_idx) == 32'(cur_depth) - 1) full_q[win_q] <= 1'b1;
					unique case (win_q)
						WIN_LONG: long_idx_q <= (32'(long_idx_q) == LONG_DEPTH - 1) ?
							'0 : long_idx_q + 1'b1;
						WIN_MEDIUM: med_idx_q <= (32'(med_idx_q) == MEDIUM_DEPTH - 1) ?
							'0 : med_idx_q + 1'b1;
						default: short_idx_q <= (32'(short_idx_q) == SHORT_DEPTH - 1) ?
							'0 : short_idx_q + 1'b1;
					endcase
				end
				ST_DIV2: if (drsp.done) held_q <= drsp.quo[SPEED_W-1:0];
				ST_DONE: if (!out_valid_q) out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			req_q   <= req_type;
			angle_q <= hall_angle;
			now_q   <= time_us;
			cmd_q   <= commanded_speed;
		end
		if (state_q == ST_RDOLD) begin
			win_q   <= win_sel;
			speed_q <= kspd_q;
			if (req_q) out_q <= '0;
		end
		if (state_q == ST_DIV1 && drsp.done) speed_q <= drsp.quo[SPEED_W-1:0];
		if (state_q == ST_DONE) out_q <= held_q;
		if (state_q == ST_CLEAR) begin
			long_mem[clr_q[LI_W-1:0]] <= '0;
			if (32'(clr_q) < MEDIUM_DEPTH) medium_mem[clr_q[MI_W-1:0]] <= '0;
			if (32'(clr_q) < SHORT_DEPTH)  short_mem[clr_q[SI_W-1:0]]  <= '0;
		end else if (state_q == ST_WRITE) begin
			unique case (win_q)
				WIN_LONG:   long_mem[long_idx_q]    <= speed_q;
				WIN_MEDIUM: medium_mem[med_idx_q]   <= speed_q;
				default:    short_mem[short_idx_q]  <= speed_q;
			endcase
		end
		if (state_q == ST_DIV1 || state_q == ST_RDOLD) begin
			unique case (win_sel)
				WIN_LONG:   old_q <= long_mem[long_idx_q];
				WIN_MEDIUM: old_q <= medium_mem[med_idx_q];
				default:    old_q <= short_mem[short_idx_q];
			endcase
		end
	end

endmodule

// ===== dv/hall_edge_speed_estimator_tb.sv =====
`timescale 1ns / 1ps
module hall_edge_speed_estimator_tb;
	import hses_pkg::*;

	class speed_scoreboard;
		logic signed [31:0] fast_thr, slow_thr;
		logic [31:0] stall_us;
		logic [23:0] kspd;
		logic [15:0] edge_angle;
		logic [31:0] edge_time;
		logic [23:0] win_long [LONG_DEPTH_DEF];
		logic [23:0] win_med [MEDIUM_DEPTH_DEF];
		logic [23:0] win_short [SHORT_DEPTH_DEF];
		int idx [3];
		bit full [3];
		longint sums [3];
		logic [23:0] held;
		logic [23:0] pending [$];
		int errors;

		function void reset_state();
			fast_thr = 800;
			slow_thr = 300;
			stall_us = 1000000;
			kspd = 5000000;
			edge_time = 0;
			clear_windows();
		endfunction

		function void clear_windows();
			foreach (win_long[i]) win_long[i] = 0;
			foreach (win_med[i]) win_med[i] = 0;
			foreach (win_short[i]) win_short[i] = 0;
			for (int w = 0; w < 3; w++) restart(w);
			held = 0;
			edge_angle = 0;
		endfunction

		function void restart(int w);
			idx[w] = 0;
			full[w] = 0;
			sums[w] = 0;
		endfunction

		function void write_reg(reg_idx_t r, logic [31:0] v);
			case (r)
				REG_FAST: fast_thr = v;
				REG_SLOW: slow_thr = v;
				REG_STALL: stall_us = v;
				REG_KSPD: kspd = v[23:0];
			endcase
		endfunction

		function void push_speed(int w, int depth, logic [23:0] spd);
			int i;
			logic [23:0] old;
			i = idx[w];
			case (w)
				WIN_LONG: old = win_long[i];
				WIN_MEDIUM: old = win_med[i];
				default: old = win_short[i];
			endcase
			if (full[w]) sums[w] -= old;
			sums[w] += spd;
			case (w)
				WIN_LONG: win_long[i] = spd;
				WIN_MEDIUM: win_med[i] = spd;
				default: win_short[i] = spd;
			endcase
			held = full[w] ? sums[w] / depth : sums[w] / (i + 1);
			i++;
			if (i >= depth) begin
				i = 0;
				full[w] = 1;
			end
			idx[w] = i;
		endfunction

		function void note_item(logic rt, logic signed [15:0] ang, logic [31:0] t,
				logic signed [31:0] cmd);
			int w;
			logic [31:0] dt;
			logic [23:0] spd;
			if (rt) clear_windows();
			else if (ang == 16'sd27308 || ang == 16'sd16384 || ang == 16'sd5461 ||
					ang == -16'sd5461 || ang == -16'sd16383 || ang == -16'sd27305) begin
				dt = t - edge_time;
				w = (cmd >= fast_thr) ? WIN_LONG : (cmd >= slow_thr) ? WIN_MEDIUM : WIN_SHORT;
				for (int k = 0; k < 3; k++) if (k != w) restart(k);
				if (w == WIN_SHORT && dt > stall_us) held = 0;
				if (ang != edge_angle) begin
					spd = (dt == 0) ? kspd : 32'(kspd) / dt;
					push_speed(w, w == WIN_LONG ? LONG_DEPTH_DEF :
						w == WIN_MEDIUM ? MEDIUM_DEPTH_DEF : SHORT_DEPTH_DEF, spd);
					edge_angle = ang;
					edge_time = t;
				end
			end
			pending.push_back(held);
		endfunction

		function void check_result(logic [23:0] got);
			logic [23:0] exp_avg;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result speed_average=%0d", got);
				return;
			end
			exp_avg = pending.pop_front();
			if (got !== exp_avg) begin
				errors++;
				if (errors <= 10)
					$display("speed_average mismatch: expected %0d actual %0d", exp_avg, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, req_type = 0, out_valid, out_ready = 0;
	logic signed [15:0] hall_angle = 0;
	logic [31:0] time_us = 0;
	logic signed [31:0] commanded_speed = 0;
	logic [23:0] speed_average;
	logic cfg_we = 0;
	logic [1:0] cfg_addr = 0;
	logic [31:0] cfg_wdata = 0;

	speed_scoreboard sb = new();
	int sent;
	bit calm;
	int hold_off;
	logic [31:0] clock_us;
	logic signed [15:0] codes [6] = '{16'sd27308, 16'sd16384, 16'sd5461,
		-16'sd5461, -16'sd16383, -16'sd27305};
	int code_pos;

	hall_edge_speed_estimator u_top (.*);

	always #2 clk = ~clk;

	function bit idle_now();
		return !calm && $urandom_range(99) < 18;
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(speed_average);
	end

	always @(negedge clk) begin
		if (!arst_n) out_ready <= 0;
		else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else out_ready <= !idle_now();
	end

	task send_item(logic rt, logic signed [15:0] ang, logic [31:0] t, logic signed [31:0] cmd);
		if (idle_now()) begin
			in_valid <= 0;
			@(negedge clk);
			while (idle_now()) @(negedge clk);
		end
		in_valid <= 1;
		req_type <= rt;
		hall_angle <= ang;
		time_us <= t;
		commanded_speed <= cmd;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(rt, ang, t, cmd);
		sent++;
		@(negedge clk);
	endtask

	task drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task write_cfg(reg_idx_t r, logic [31:0] v);
		cfg_we <= 1;
		cfg_addr <= r;
		cfg_wdata <= v;
		sb.write_reg(r, v);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task random_edge(int mode);
		logic signed [15:0] ang;
		logic signed [31:0] cmd;
		int r;
		r = $urandom_range(99);
		if (r < 75) begin
			code_pos = (code_pos + 1 + $urandom_range(4)) % 6;
			ang = codes[code_pos];
		end else if (r < 85) ang = codes[code_pos];
		else ang = 16'($urandom);
		case ($urandom_range(3))
			0: clock_us += $urandom_range(3);
			1: clock_us += $urandom_range(5000);
			2: clock_us += $urandom_range(2000000);
			default: clock_us += $urandom;
		endcase
		case (mode)
			0: cmd = $urandom_range(1200);
			1: cmd = 1000;
			default: cmd = $urandom;
		endcase
		send_item($urandom_range(99) < 2, ang, clock_us, cmd);
	endtask

	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		sb.reset_state();
		repeat (7) @(negedge clk);
		arst_n <= 1;
		clock_us = 0;
		// directed
		send_item(0, 16'sd27308, 0, 0);
		send_item(0, 16'sd27308, 10, 0);
		send_item(0, 16'sd16384, 100, 500);
		send_item(0, 16'sd5461, 100, 500);
		send_item(0, -16'sd5461, 3000, 800);
		send_item(0, -16'sd16383, 3100, 32'sh7fffffff);
		send_item(0, 16'sh7fff, 3200, 900);
		send_item(0, 16'sh8000, 3200, 32'sh80000000);
		send_item(0, -16'sd27305, 5003200, 32'sh80000000);
		send_item(0, 16'sd27308, 32'hffffffff, 0);
		send_item(1, 16'sh5555, 32'haaaaaaaa, 32'sh55555555);
		send_item(0, 16'sd16384, 32'hffffffff, 0);
		for (int i = 0; i < 7; i++) send_item(0, codes[i % 6], 32'hffffffff + 1 + i, 10);
		drain();
		write_cfg(REG_FAST, 32'h80000000);
		write_cfg(REG_SLOW, 32'h7fffffff);
		write_cfg(REG_STALL, 0);
		write_cfg(REG_KSPD, 32'h00ffffff);
		for (int i = 0; i < 6; i++) send_item(0, codes[i], 32'hfffffff0 + i * 3, i);
		drain();
		write_cfg(REG_FAST, 32'h7fffffff);
		write_cfg(REG_SLOW, 32'h80000000);
		write_cfg(REG_STALL, 32'hffffffff);
		write_cfg(REG_KSPD, 1);
		for (int i = 0; i < 6; i++) send_item(0, codes[i], i, 0);
		drain();
		write_cfg(REG_FAST, 800);
		write_cfg(REG_SLOW, 300);
		write_cfg(REG_STALL, 5000);
		write_cfg(REG_KSPD, 5000000);
		// long stall while the sender keeps offering
		hold_off = 400;
		for (int i = 0; i < 20; i++) random_edge(0);
		drain();
		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 2) begin
				write_cfg(REG_FAST, $urandom);
				write_cfg(REG_SLOW, $urandom);
				write_cfg(REG_STALL, $urandom_range(100000));
				write_cfg(REG_KSPD, $urandom_range(24'hffffff, 1));
			end else if (ph == 3) begin
				write_cfg(REG_FAST, 800);
				write_cfg(REG_SLOW, 300);
				write_cfg(REG_STALL, 1000000);
				write_cfg(REG_KSPD, 5000000);
			end
			calm = (ph == 1);
			for (int i = 0; i < 450; i++) random_edge(ph == 1 ? 1 : ph == 2 ? 2 : 0);
			calm = 0;
			drain();
		end
		if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== hall_edge_speed_estimator.f =====
src/hses_pkg.sv
src/hses_divider.sv
src/hall_edge_speed_estimator.sv
dv/hall_edge_speed_estimator_tb.sv
